>>> src/rvt_pkg.sv
// Shared types and constants for the ray voxel traversal block.
`timescale 1ns / 1ps
package rvt_pkg;

  localparam int COORD_W = 32;  // width of points, voxel size and emitted keys
  localparam int KEY_W   = 34;  // internal key width, holds any floor quotient plus walk
  localparam int T_W     = 64;  // ray parameter width
  localparam int CNT_W   = 7;   // cell counter and clamped budget, holds 64

  localparam int DEF_MAX_CELLS      = 64;
  localparam int DEF_RAY_PARAM_FRAC = 32;

  // One axis of a set-up ray
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] endk;
    logic [T_W-1:0]          tmax;
    logic [T_W-1:0]          tdel;
    logic                    up;
    logic                    down;
  } rvt_axis_t;

  // Request handed from setup to walker
  typedef struct packed {
    rvt_axis_t [2:0]  ax;
    logic [CNT_W-1:0] budget;
  } rvt_ray_t;

endpackage

>>> src/rvt_div.sv
// Restoring divider, one quotient bit per cycle, dividend fed MSB first.
`timescale 1ns / 1ps
module rvt_div #(
  parameter int QW = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rvt_pkg::COORD_W-1:0]   dvd,
  input  logic [rvt_pkg::COORD_W-1:0]   den,
  input  logic [$clog2(QW+1)-1:0]       iters,
  output logic [QW-1:0]                 quo,
  output logic [rvt_pkg::COORD_W-1:0]   rem,
  output logic                          done
);
  import rvt_pkg::*;

  localparam int CW = $clog2(QW+1);

  logic [COORD_W-1:0] dvd_r;
  logic [COORD_W-1:0] rem_r;
  logic [QW-1:0]      quo_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [COORD_W:0]   trial;
  logic [COORD_W:0]   diff;
  logic               ge;

  assign trial = {rem_r, dvd_r[COORD_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[COORD_W-2:0], 1'b0};
      rem_r <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

>>> src/rvt_front.sv
// Ray setup: cell keys, first crossings and step increments per axis.
`timescale 1ns / 1ps
module rvt_front #(
  parameter int MAX_CELLS           = rvt_pkg::DEF_MAX_CELLS,
  parameter int RAY_PARAM_FRAC_BITS = rvt_pkg::DEF_RAY_PARAM_FRAC
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0][rvt_pkg::COORD_W-1:0]      p0,
  input  logic [2:0][rvt_pkg::COORD_W-1:0]      pe,
  input  logic [rvt_pkg::COORD_W-1:0]           voxel_size,
  input  logic                                  q_full,
  output logic                                  push,
  output rvt_pkg::rvt_ray_t                     ray
);
  import rvt_pkg::*;

  localparam int QW = COORD_W + RAY_PARAM_FRAC_BITS;
  localparam int IW = $clog2(QW+1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FLR0 = 3'd1;
  localparam logic [2:0] S_FLR1 = 3'd2;
  localparam logic [2:0] S_FIX0 = 3'd3;
  localparam logic [2:0] S_FIX1 = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0] state_r;
  logic       go_r;
  logic       accept;
  logic       done;
  logic       floor_st;
  logic [COORD_W-1:0] v;

  logic [2:0][COORD_W-1:0] p0_r, pe_r, rmod_r;
  logic signed [2:0][KEY_W-1:0] key_r, end_r;
  logic [2:0][T_W-1:0] tmax_r, tdel_r;
  logic [2:0] done_w, up_w, down_w;
  logic [2:0][KEY_W-1:0] absd;
  logic [KEY_W+1:0] bsum;

  assign v        = (voxel_size == '0) ? COORD_W'(1) : voxel_size;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign done     = &done_w;
  assign floor_st = (state_r == S_FLR0) || (state_r == S_FLR1);
  assign push     = (state_r == S_PUSH) && !q_full;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [COORD_W:0]   d_up, d_dn;
    logic [COORD_W-1:0] ad, pt, pabs, bdist, dvd, den, rf;
    logic [QW-1:0]      quo;
    logic [KEY_W-1:0]   qext, keyf;
    logic [COORD_W-1:0] rmodf;
    logic [T_W-1:0]     tq;
    logic signed [KEY_W-1:0] ed;

    assign up_w[g]   = $signed(pe_r[g]) > $signed(p0_r[g]);
    assign down_w[g] = $signed(pe_r[g]) < $signed(p0_r[g]);
    assign d_up = {pe_r[g][COORD_W-1], pe_r[g]} - {p0_r[g][COORD_W-1], p0_r[g]};
    assign d_dn = {p0_r[g][COORD_W-1], p0_r[g]} - {pe_r[g][COORD_W-1], pe_r[g]};
    assign ad   = up_w[g] ? d_up[COORD_W-1:0] : d_dn[COORD_W-1:0];

    assign pt    = (state_r == S_FLR0) ? p0_r[g] : pe_r[g];
    assign pabs  = pt[COORD_W-1] ? (~pt + COORD_W'(1)) : pt;
    assign bdist = up_w[g] ? (v - rmod_r[g]) : rmod_r[g];

    always_comb begin
      if (floor_st) begin
        dvd = pabs;
        den = v;
      end else begin
        dvd = (state_r == S_FIX0) ? bdist : v;
        den = ad;
      end
    end

    rvt_div #(.QW(QW)) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (go_r),
      .dvd   (dvd),
      .den   (den),
      .iters (floor_st ? IW'(COORD_W) : IW'(QW)),
      .quo   (quo),
      .rem   (rf),
      .done  (done_w[g])
    );

    // floor of signed point over size, and its floor remainder
    assign qext  = {{(KEY_W-COORD_W){1'b0}}, quo[COORD_W-1:0]};
    assign keyf  = pt[COORD_W-1] ? (~qext + KEY_W'(1) - KEY_W'(rf != '0)) : qext;
    assign rmodf = pt[COORD_W-1] ? ((rf != '0) ? (v - rf) : '0) : rf;

    if (QW > T_W) begin : g_sat
      assign tq = (|quo[QW-1:T_W]) ? '1 : quo[T_W-1:0];
    end else if (QW == T_W) begin : g_eq
      assign tq = quo;
    end else begin : g_ext
      assign tq = {{(T_W-QW){1'b0}}, quo};
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        p0_r[g] <= p0[g];
        pe_r[g] <= pe[g];
      end
      if (done) begin
        unique case (state_r)
          S_FLR0: begin
            key_r[g]  <= keyf;
            rmod_r[g] <= rmodf;
          end
          S_FLR1: end_r[g] <= keyf;
          S_FIX0: tmax_r[g] <= (up_w[g] || down_w[g]) ? tq : '1;
          S_FIX1: tdel_r[g] <= (up_w[g] || down_w[g]) ? tq : '0;
          default: ;
        endcase
      end
    end

    assign ed      = end_r[g] - key_r[g];
    assign absd[g] = ed[KEY_W-1] ? (-ed) : ed;

    assign ray.ax[g].key  = key_r[g];
    assign ray.ax[g].endk = end_r[g];
    assign ray.ax[g].tmax = tmax_r[g];
    assign ray.ax[g].tdel = tdel_r[g];
    assign ray.ax[g].up   = up_w[g];
    assign ray.ax[g].down = down_w[g];
  end

  // step budget, clamped: the walk never runs past MAX_CELLS anyway
  assign bsum = (KEY_W+2)'(3) + {2'b0, absd[0]} + {2'b0, absd[1]} + {2'b0, absd[2]};
  assign ray.budget = (bsum > (KEY_W+2)'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : bsum[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept) begin
          state_r <= S_FLR0;
          go_r    <= 1'b1;
        end
        S_FLR0: if (done) begin
          state_r <= S_FLR1;
          go_r    <= 1'b1;
        end
        S_FLR1: if (done) begin
          state_r <= S_FIX0;
          go_r    <= 1'b1;
        end
        S_FIX0: if (done) begin
          state_r <= S_FIX1;
          go_r    <= 1'b1;
        end
        S_FIX1: if (done) begin
          state_r <= S_PUSH;
        end
        S_PUSH: if (!q_full) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/rvt_queue.sv
// Two-entry queue of set-up rays between setup and walker.
`timescale 1ns / 1ps
module rvt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rvt_pkg::rvt_ray_t din,
  output logic              full,
  input  logic              pop,
  output rvt_pkg::rvt_ray_t dout,
  output logic              valid
);
  import rvt_pkg::*;

  rvt_ray_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> src/rvt_walk.sv
// DDA walker: steps the axes with the smallest next crossing, one cell per unstalled cycle.
`timescale 1ns / 1ps
module rvt_walk #(
  parameter int MAX_CELLS = rvt_pkg::DEF_MAX_CELLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rvt_pkg::rvt_ray_t             ray,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rvt_pkg::COORD_W-1:0]   out_cell_x,
  output logic [rvt_pkg::COORD_W-1:0]   out_cell_y,
  output logic [rvt_pkg::COORD_W-1:0]   out_cell_z,
  output logic                          out_last_cell,
  output logic                          out_cut_short
);
  import rvt_pkg::*;

  localparam logic [1:0] W_IDLE  = 2'd0;
  localparam logic [1:0] W_FIRST = 2'd1;
  localparam logic [1:0] W_WALK  = 2'd2;

  logic [1:0]       st_r;
  rvt_axis_t [2:0]  ax_r;
  logic [CNT_W-1:0] bud_r, n_r;
  logic             ov_r, last_r, cut_r;
  logic [2:0][COORD_W-1:0] cell_r;

  logic            adv, same, nsame, go_on;
  logic [T_W-1:0]  m01, tmin;
  logic [2:0]      hit;
  logic signed [2:0][KEY_W-1:0] nkey;
  logic [2:0][T_W-1:0] ntmax;

  assign adv = !ov_r || !out_stall;
  assign pop = (st_r == W_IDLE) && q_valid;

  assign m01  = (ax_r[0].tmax < ax_r[1].tmax) ? ax_r[0].tmax : ax_r[1].tmax;
  assign tmin = (ax_r[2].tmax < m01) ? ax_r[2].tmax : m01;

  for (genvar g = 0; g < 3; g++) begin : g_ax
    logic [T_W:0]            s;
    logic signed [KEY_W-1:0] stp;
    assign hit[g]   = (ax_r[g].tmax == tmin);
    assign s        = {1'b0, ax_r[g].tmax} + {1'b0, ax_r[g].tdel};
    assign stp      = ax_r[g].up ? KEY_W'(1) : (ax_r[g].down ? '1 : '0);
    assign nkey[g]  = hit[g] ? (ax_r[g].key + stp) : ax_r[g].key;
    assign ntmax[g] = hit[g] ? (s[T_W] ? '1 : s[T_W-1:0]) : ax_r[g].tmax;
  end

  assign same  = (ax_r[0].key == ax_r[0].endk) && (ax_r[1].key == ax_r[1].endk)
              && (ax_r[2].key == ax_r[2].endk);
  assign nsame = (nkey[0] == ax_r[0].endk) && (nkey[1] == ax_r[1].endk)
              && (nkey[2] == ax_r[2].endk);
  assign go_on = (n_r <= bud_r) && (n_r < CNT_W'(MAX_CELLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= W_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (adv) ov_r <= (st_r == W_FIRST) || (st_r == W_WALK);
      unique case (st_r)
        W_IDLE: if (q_valid) begin
          ax_r  <= ray.ax;
          bud_r <= ray.budget;
          st_r  <= W_FIRST;
        end
        W_FIRST: if (adv) begin
          for (int a = 0; a < 3; a++) cell_r[a] <= ax_r[a].key[COORD_W-1:0];
          last_r <= same;
          cut_r  <= 1'b0;
          n_r    <= CNT_W'(1);
          st_r   <= same ? W_IDLE : W_WALK;
        end
        W_WALK: if (adv) begin
          if (go_on) begin
            for (int a = 0; a < 3; a++) begin
              cell_r[a]     <= nkey[a][COORD_W-1:0];
              ax_r[a].key   <= nkey[a];
              ax_r[a].tmax  <= ntmax[a];
            end
            last_r <= nsame;
            cut_r  <= 1'b0;
            n_r    <= n_r + CNT_W'(1);
            if (nsame) st_r <= W_IDLE;
          end else begin
            for (int a = 0; a < 3; a++) cell_r[a] <= ax_r[a].endk[COORD_W-1:0];
            last_r <= 1'b1;
            cut_r  <= 1'b1;
            st_r   <= W_IDLE;
          end
        end
        default: st_r <= W_IDLE;
      endcase
    end
  end

  assign out_valid     = ov_r;
  assign out_cell_x    = cell_r[0];
  assign out_cell_y    = cell_r[1];
  assign out_cell_z    = cell_r[2];
  assign out_last_cell = last_r;
  assign out_cut_short = cut_r;

endmodule

>>> src/ray_voxel_traversal.sv
// Top level of the 3D voxel ray traversal block.
// Usage:
//  - Input channel (in_valid / in_stall): one request is a ray, start and end
//    points in signed Q16.16. Taken when in_valid is high and in_stall is low.
//  - Output channel (out_valid / out_stall): one request per visited voxel,
//    start cell first, end cell last with out_last_cell set; out_cut_short
//    flags a walk stopped by the cell limit or the step budget.
//  - cfg_wr_en / cfg_wr_data write voxel_size (0 acts as 1). Write only idle.
//  - Setup runs three dividers in lock step, one bit per cycle: two floor
//    divisions of 32 steps and two fixed-point divisions of
//    32 + RAY_PARAM_FRAC_BITS steps, then the push into the queue, which
//    waits while the queue is full. This sets the input rate.
//  - The walker emits one cell per cycle, while out_stall is low, once a
//    ray sits in the two-entry queue, so the next ray's setup overlaps the
//    current walk.
//  - out_stall holds the output register; the walker simply waits, and the
//    setup side keeps working until the queue is full.
//  - Reset (rst_n low, synchronous) empties queue and output, and sets
//    voxel_size to 1.0.
`timescale 1ns / 1ps
module ray_voxel_traversal #(
  parameter int MAX_CELLS           = rvt_pkg::DEF_MAX_CELLS,
  parameter int RAY_PARAM_FRAC_BITS = rvt_pkg::DEF_RAY_PARAM_FRAC
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rvt_pkg::COORD_W-1:0] in_start_x,
  input  logic [rvt_pkg::COORD_W-1:0] in_start_y,
  input  logic [rvt_pkg::COORD_W-1:0] in_start_z,
  input  logic [rvt_pkg::COORD_W-1:0] in_end_x,
  input  logic [rvt_pkg::COORD_W-1:0] in_end_y,
  input  logic [rvt_pkg::COORD_W-1:0] in_end_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rvt_pkg::COORD_W-1:0] out_cell_x,
  output logic [rvt_pkg::COORD_W-1:0] out_cell_y,
  output logic [rvt_pkg::COORD_W-1:0] out_cell_z,
  output logic                        out_last_cell,
  output logic                        out_cut_short,
  input  logic                        cfg_wr_en,
  input  logic [rvt_pkg::COORD_W-1:0] cfg_wr_data
);
  import rvt_pkg::*;

  logic [COORD_W-1:0] voxel_size_r;
  rvt_ray_t           f_ray, q_ray;
  logic               push, q_full, pop, q_valid;

  // voxel size register, 1.0 after reset
  always_ff @(posedge clk) begin
    if (!rst_n) voxel_size_r <= COORD_W'(65536);
    else if (cfg_wr_en) voxel_size_r <= cfg_wr_data;
  end

  rvt_front #(
    .MAX_CELLS           (MAX_CELLS),
    .RAY_PARAM_FRAC_BITS (RAY_PARAM_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .p0         ({in_start_z, in_start_y, in_start_x}),
    .pe         ({in_end_z, in_end_y, in_end_x}),
    .voxel_size (voxel_size_r),
    .q_full     (q_full),
    .push       (push),
    .ray        (f_ray)
  );

  // decouples setup from walk
  rvt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_ray),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_ray),
    .valid (q_valid)
  );

  rvt_walk #(
    .MAX_CELLS (MAX_CELLS)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .ray           (q_ray),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_cell_z    (out_cell_z),
    .out_last_cell (out_last_cell),
    .out_cut_short (out_cut_short)
  );

endmodule
